// ----- sv/bba_pkg.sv -----
package bba_pkg;

    // Tree geometry: node i has children 2i+1 and 2i+2.
    localparam int MAX_DEPTH  = 10;
    localparam int NODE_COUNT = (2 << MAX_DEPTH) - 1;
    localparam int ADDR_W     = $clog2(NODE_COUNT);
    localparam int DEPTH_W    = $clog2(MAX_DEPTH + 1);

    // Configuration register indexes.
    localparam int CFG_IDX_W     = 8;
    localparam int CFG_BASE_ADDR = 0;
    localparam int CFG_POOL_LOG2 = 1;
    localparam int POOL_RESET    = 20;

    typedef enum logic [1:0] {
        NS_ABSENT   = 2'd0,
        NS_FREE     = 2'd1,
        NS_SPLIT    = 2'd2,
        NS_OCCUPIED = 2'd3
    } t_node_state;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_SPACE  = 2'd1,
        ST_BAD_OWNER = 2'd2,
        ST_BAD_SIZE  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EVAL,
        S_WR_LEFT,
        S_WR_RIGHT,
        S_BACK,
        S_RESULT
    } t_fsm;

    // One access to the node state memory.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        t_node_state       wdata;
    } t_ram_req;

    // Block size of a node at the given depth; zero below the one-byte level.
    function automatic logic [31:0] node_size(input logic [4:0] pool_log2,
                                              input logic [DEPTH_W-1:0] depth);
        logic [4:0] d;
        d = 5'(depth);
        if (d <= pool_log2) begin
            return 32'd1 << (pool_log2 - d);
        end
        return 32'd0;
    endfunction

endpackage

// ----- sv/bba_ifs.sv -----
// Allocation request channel.
interface bba_req_if;
    logic        valid;
    logic        ready;
    logic [31:0] owner_id;
    logic [31:0] request_size;

    modport source (output valid, output owner_id, output request_size, input ready);
    modport sink   (input valid, input owner_id, input request_size, output ready);
endinterface

// Allocation result channel.
interface bba_rsp_if import bba_pkg::*;;
    logic        valid;
    logic        ready;
    logic [31:0] block_address;
    t_status     status;

    modport source (output valid, output block_address, output status, input ready);
    modport sink   (input valid, input block_address, input status, output ready);
endinterface

// Configuration register write channel.
interface bba_cfg_if import bba_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] addr;
    logic [31:0]          data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

// ----- sv/bba_node_ram.sv -----
module bba_node_ram import bba_pkg::*; (
    input  logic        i_clk,
    input  t_ram_req    i_req,
    output t_node_state o_rdata
);

    t_node_state r_mem [NODE_COUNT];
    t_node_state r_rdata;

    // Single port: one write or one read per cycle, read data registered.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/bba_search.sv -----
module bba_search import bba_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [31:0]    i_base,
    input  logic [4:0]     i_pool_log2,
    bba_req_if.sink        i_req,
    bba_rsp_if.source      o_rsp,
    output t_ram_req       o_ram,
    input  t_node_state    i_ram_rdata
);

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_DEPTH);
    localparam logic [ADDR_W-1:0]  LAST_NODE = ADDR_W'(NODE_COUNT - 1);

    t_fsm               r_state, n_state;
    logic [ADDR_W-1:0]  r_idx, n_idx;
    logic [DEPTH_W-1:0] r_depth, n_depth;
    logic [31:0]        r_offset, n_offset;
    logic [31:0]        r_want, n_want;
    t_status            r_status, n_status;
    logic               r_out_valid;
    logic [31:0]        r_out_addr;
    t_status            r_out_status;

    logic [31:0]        w_size;
    logic [31:0]        w_half;
    logic [ADDR_W-1:0]  w_left;
    logic [ADDR_W-1:0]  w_right;
    logic               w_at_max;
    logic               w_fail;
    logic               w_take;
    logic               w_split;
    logic               w_slot_free;
    logic               w_load;

    // Node geometry for the current position of the walk.
    always_comb begin
        w_size   = node_size(i_pool_log2, r_depth);
        w_half   = w_size >> 1;
        w_left   = ADDR_W'({r_idx, 1'b0} + {{ADDR_W{1'b0}}, 1'b1});
        w_right  = w_left + ADDR_W'(1);
        w_at_max = (r_depth == DEPTH_MAX);
    end

    // Decision on the node just read from memory.
    always_comb begin
        w_fail  = (i_ram_rdata == NS_ABSENT) || (i_ram_rdata == NS_OCCUPIED)
                  || (w_size < r_want);
        w_take  = !w_fail && (i_ram_rdata == NS_FREE)
                  && ((w_size == r_want) || (w_half < r_want) || w_at_max);
        w_split = !w_fail && (i_ram_rdata == NS_FREE) && !w_take;
    end

    assign w_slot_free = !r_out_valid || o_rsp.ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_idx == LAST_NODE) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    if ((i_req.owner_id == 32'd0) || (i_req.request_size == 32'd0)) begin
                        n_state = S_RESULT;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (w_fail) begin
                    n_state = S_BACK;
                end else if (w_take) begin
                    n_state = S_RESULT;
                end else if (w_split) begin
                    n_state = S_WR_LEFT;
                end else if (!w_at_max) begin
                    n_state = S_READ;
                end else begin
                    n_state = S_BACK;
                end
            end
            S_WR_LEFT: begin
                n_state = S_WR_RIGHT;
            end
            S_WR_RIGHT: begin
                n_state = S_READ;
            end
            S_BACK: begin
                if (r_depth == '0) begin
                    n_state = S_RESULT;
                end else if (r_idx[0]) begin
                    n_state = S_READ;
                end
            end
            S_RESULT: begin
                if (w_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs of the state machine: memory access, handshake and result load.
    always_comb begin
        o_ram.we    = 1'b0;
        o_ram.addr  = r_idx;
        o_ram.wdata = NS_ABSENT;
        i_req.ready = 1'b0;
        w_load      = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_ram.we    = 1'b1;
                o_ram.wdata = (r_idx == '0) ? NS_FREE : NS_ABSENT;
            end
            S_IDLE: begin
                i_req.ready = 1'b1;
            end
            S_EVAL: begin
                o_ram.we    = w_take || w_split;
                o_ram.wdata = w_take ? NS_OCCUPIED : NS_SPLIT;
            end
            S_WR_LEFT: begin
                o_ram.we    = 1'b1;
                o_ram.addr  = w_left;
                o_ram.wdata = NS_FREE;
            end
            S_WR_RIGHT: begin
                o_ram.we    = 1'b1;
                o_ram.addr  = w_right;
                o_ram.wdata = NS_FREE;
            end
            S_RESULT: begin
                w_load = w_slot_free;
            end
            default: begin
                o_ram.we = 1'b0;
            end
        endcase
    end

    // Walk position, offset and status. During the clearing pass the node
    // index doubles as the sweep counter.
    always_comb begin
        n_idx    = r_idx;
        n_depth  = r_depth;
        n_offset = r_offset;
        n_want   = r_want;
        n_status = r_status;
        case (r_state)
            S_CLEAR: begin
                n_idx = (r_idx == LAST_NODE) ? '0 : r_idx + ADDR_W'(1);
            end
            S_IDLE: begin
                n_idx    = '0;
                n_depth  = '0;
                n_offset = '0;
                n_want   = i_req.request_size;
                if (i_req.owner_id == 32'd0) begin
                    n_status = ST_BAD_OWNER;
                end else if (i_req.request_size == 32'd0) begin
                    n_status = ST_BAD_SIZE;
                end else begin
                    n_status = ST_OK;
                end
            end
            S_EVAL: begin
                // A split node that was already split is entered at once.
                if (!w_fail && !w_take && !w_split && !w_at_max) begin
                    n_idx   = w_left;
                    n_depth = r_depth + DEPTH_W'(1);
                end
            end
            S_WR_RIGHT: begin
                n_idx   = w_left;
                n_depth = r_depth + DEPTH_W'(1);
            end
            S_BACK: begin
                if (r_depth == '0) begin
                    n_status = ST_NO_SPACE;
                end else if (r_idx[0]) begin
                    // Left child failed: try its right sibling.
                    n_idx    = r_idx + ADDR_W'(1);
                    n_offset = r_offset + w_size;
                end else begin
                    // Right child failed: the parent fails as well.
                    n_idx    = (r_idx - ADDR_W'(1)) >> 1;
                    n_offset = r_offset - w_size;
                    n_depth  = r_depth - DEPTH_W'(1);
                end
            end
            default: begin
                n_idx = r_idx;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_depth  <= n_depth;
        r_offset <= n_offset;
        r_want   <= n_want;
        r_status <= n_status;
        if (w_load) begin
            r_out_status <= r_status;
            r_out_addr   <= (r_status == ST_OK) ? i_base + r_offset : 32'd0;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.block_address = r_out_addr;
    assign o_rsp.status        = r_out_status;

endmodule

// ----- sv/buddy_block_allocator.sv -----
// Buddy block allocator. Each request item (owner_id, request_size) walks an
// 11-level buddy tree of 2047 nodes, depth first and left before right, and
// returns one result item: the granted block address (base_address plus block
// offset, wrapping at 2^32) with status ok, or status no space, invalid owner
// or invalid size. Blocks are never freed. The node states live in a single
// port memory with registered read data, so each node visited is read in
// S_READ and judged in S_EVAL; a split writes the two children in S_WR_LEFT
// and S_WR_RIGHT, a failed node climbs back a level at a time through
// S_BACK, and an invalid request goes from S_IDLE straight to S_RESULT.
// One request is in work at a time; a finished result waits in an output
// register while the next request is taken. After reset a clearing pass
// writes all 2047 nodes, one per cycle, before the first request is taken;
// configuration writes are accepted at all times but must only be issued
// while no request is in work.
module buddy_block_allocator import bba_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bba_req_if.sink    i_req,
    bba_rsp_if.source  o_rsp,
    bba_cfg_if.sink    i_cfg
);

    logic [31:0] r_base;
    logic [4:0]  r_pool_log2;
    t_ram_req    w_ram_req;
    t_node_state w_ram_rdata;

    // Configuration registers.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= 32'd0;
            r_pool_log2 <= 5'(POOL_RESET);
        end else if (i_cfg.valid) begin
            if (i_cfg.addr == CFG_IDX_W'(CFG_BASE_ADDR)) begin
                r_base <= i_cfg.data;
            end else if (i_cfg.addr == CFG_IDX_W'(CFG_POOL_LOG2)) begin
                r_pool_log2 <= i_cfg.data[4:0];
            end
        end
    end

    bba_search u_search (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_base      (r_base),
        .i_pool_log2 (r_pool_log2),
        .i_req       (i_req),
        .o_rsp       (o_rsp),
        .o_ram       (w_ram_req),
        .i_ram_rdata (w_ram_rdata)
    );

    bba_node_ram u_node_ram (
        .i_clk   (i_clk),
        .i_req   (w_ram_req),
        .o_rdata (w_ram_rdata)
    );

endmodule

// ----- sv/bba_checker.sv -----
module bba_checker import bba_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [31:0] i_rsp_address,
    input logic [1:0]  i_rsp_status
);

    // A refused or failed request never carries an address.
    a_addr_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && (i_rsp_status != ST_OK)) |-> (i_rsp_address == 32'd0))
        else $error("nonzero address with error status");

    // Only one request is in work: taking one closes the input next cycle.
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request taken while another is in work");

    // The clearing pass after reset holds off requests.
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_req_ready)
        else $error("request taken before the node memory was cleared");

    // A stalled result holds its value.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_rsp_address) && $stable(i_rsp_status)))
        else $error("stalled result changed");

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_rsp_address (o_rsp.block_address),
    .i_rsp_status  (o_rsp.status)
);

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import bba_pkg::*;

    // Runs shorter than this many clock cycles; a worst case request walks
    // the whole tree, and this is several times the slowest correct run of
    // about 300 requests plus the long output stall.
    localparam int LIMIT_CYCLES = 8_000_000;

    // Length of the long output stall that fills the block and blocks requests.
    localparam int HOLD_OFF_CYCLES = 4000;

    typedef struct {
        logic [31:0] block_address;
        t_status     status;
    } alloc_result_t;

    // Keeps a copy of the buddy tree and the registers, works out the grant for
    // each accepted request and checks the returned items in order.
    class alloc_ledger;
        t_node_state     tree [NODE_COUNT];
        logic [31:0]     base_address;
        int unsigned     pool_log2;
        alloc_result_t   grants_due [$];
        int unsigned     mismatches;
        int unsigned     status_seen [4];

        function new();
            foreach (tree[i]) begin
                tree[i] = NS_ABSENT;
            end
            tree[0]      = NS_FREE;
            base_address = '0;
            pool_log2    = POOL_RESET;
            mismatches   = 0;
            foreach (status_seen[i]) begin
                status_seen[i] = 0;
            end
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
            if (idx == CFG_BASE_ADDR) begin
                base_address = data;
            end else if (idx == CFG_POOL_LOG2) begin
                pool_log2 = data[4:0];
            end
        endfunction

        function int unsigned pending();
            return grants_due.size();
        endfunction

        // Depth first, left before right. Free nodes are taken whole or split;
        // sizes follow the current pool size at every search.
        function bit find_block(int unsigned idx, int unsigned depth,
                                longint unsigned offset, longint unsigned want,
                                output longint unsigned found);
            longint unsigned span;
            longint unsigned half;
            t_node_state     st;
            found = 0;
            if (idx >= NODE_COUNT) begin
                return 1'b0;
            end
            st   = tree[idx];
            span = (depth <= pool_log2) ? (64'd1 << (pool_log2 - depth)) : 64'd0;
            if (st == NS_ABSENT || st == NS_OCCUPIED || span < want) begin
                return 1'b0;
            end
            half = span >> 1;
            if (st == NS_FREE) begin
                if (span == want || half < want || depth >= MAX_DEPTH) begin
                    tree[idx] = NS_OCCUPIED;
                    found     = offset;
                    return 1'b1;
                end
                tree[idx]       = NS_SPLIT;
                tree[2*idx + 1] = NS_FREE;
                tree[2*idx + 2] = NS_FREE;
            end
            if (depth >= MAX_DEPTH) begin
                return 1'b0;
            end
            if (find_block(2*idx + 1, depth + 1, offset, want, found)) begin
                return 1'b1;
            end
            return find_block(2*idx + 2, depth + 1, offset + half, want, found);
        endfunction

        function void note_request(logic [31:0] owner, logic [31:0] size);
            alloc_result_t   grant;
            longint unsigned offset;
            grant.block_address = '0;
            if (owner == 0) begin
                grant.status = ST_BAD_OWNER;
            end else if (size == 0) begin
                grant.status = ST_BAD_SIZE;
            end else if (find_block(0, 0, 0, size, offset)) begin
                grant.status        = ST_OK;
                grant.block_address = base_address + offset[31:0];
            end else begin
                grant.status = ST_NO_SPACE;
            end
            grants_due.push_back(grant);
        endfunction

        function void check_result(logic [31:0] addr, t_status status);
            alloc_result_t grant;
            if (grants_due.size() == 0) begin
                $error("unexpected result item: block_address %h status %0d", addr, status);
                mismatches++;
                return;
            end
            grant = grants_due.pop_front();
            status_seen[grant.status]++;
            if (status !== grant.status) begin
                $error("status: expected %0d, got %0d", grant.status, status);
                mismatches++;
            end
            if (addr !== grant.block_address) begin
                $error("block_address: expected %h, got %h", grant.block_address, addr);
                mismatches++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        req_idle_en;
    logic        rsp_idle_en;
    int unsigned rsp_hold_cycles;
    int unsigned cycle_count;
    int unsigned settings_used;
    alloc_ledger ledger = new();

    bba_req_if req_if ();
    bba_rsp_if rsp_if ();
    bba_cfg_if cfg_if ();

    buddy_block_allocator u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    // Free-running clock.
    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog on the total run length.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                     cycle_count, ledger.pending());
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result side: random stalls plus an optional long hold-off.
    initial begin
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (rsp_hold_cycles > 0) begin
                rsp_if.ready = 1'b0;
                rsp_hold_cycles--;
            end else begin
                rsp_if.ready = !(rsp_idle_en && $urandom_range(0, 99) < 10);
            end
        end
    end

    // Sample every handshake at the rising edge.
    always @(posedge clk) begin
        if (rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                ledger.check_result(rsp_if.block_address, rsp_if.status);
            end
            if (req_if.valid && req_if.ready) begin
                ledger.note_request(req_if.owner_id, req_if.request_size);
            end
            if (cfg_if.valid && cfg_if.ready) begin
                ledger.set_reg(cfg_if.addr, cfg_if.data);
            end
        end
    end

    // Offer one request item, with an occasional gap first, and wait until it is taken.
    task automatic send_request(input logic [31:0] owner, input logic [31:0] size);
        int unsigned gap;
        gap = (req_idle_en && $urandom_range(0, 99) < 10) ? $urandom_range(1, 6) : 0;
        @(negedge clk);
        if (gap != 0) begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_if.valid        = 1'b1;
        req_if.owner_id     = owner;
        req_if.request_size = size;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
    endtask

    task automatic program_reg(input int idx, input logic [31:0] data);
        @(negedge clk);
        cfg_if.valid = 1'b1;
        cfg_if.addr  = CFG_IDX_W'(idx);
        cfg_if.data  = data;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    // Stop offering requests and wait until every grant has come back.
    task automatic wait_for_results();
        @(negedge clk);
        req_if.valid = 1'b0;
        while (ledger.pending() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic set_pool(input logic [31:0] base, input logic [4:0] pool_log2);
        program_reg(CFG_BASE_ADDR, base);
        program_reg(CFG_POOL_LOG2, 32'(pool_log2));
        settings_used++;
    endtask

    function automatic logic [31:0] pick_owner();
        return ($urandom_range(0, 19) == 0) ? 32'd0 : 32'($urandom());
    endfunction

    // Mostly sizes up to a few KiB so searches stay short; some zeros,
    // full-range values and exact powers of two.
    function automatic logic [31:0] pick_size(input int unsigned pool_log2);
        int unsigned top;
        top = (pool_log2 < 12) ? pool_log2 : 12;
        case ($urandom_range(0, 15))
            0:       return 32'd0;
            1:       return 32'($urandom());
            2:       return 32'd1 << $urandom_range(0, 31);
            3:       return 32'd1 << $urandom_range(0, top);
            default: return 32'($urandom_range(1, 32'd1 << $urandom_range(0, top)));
        endcase
    endfunction

    // One random phase under a fresh register setting.
    task automatic run_phase(input logic [31:0] base, input logic [4:0] pool_log2,
                             input int n_items, input logic idle_en, input int hold);
        wait_for_results();
        set_pool(base, pool_log2);
        req_idle_en     = idle_en;
        rsp_idle_en     = idle_en;
        rsp_hold_cycles = hold;
        repeat (n_items) begin
            send_request(pick_owner(), pick_size(pool_log2));
        end
    endtask

    initial begin
        rst_n               = 1'b0;
        req_if.valid        = 1'b0;
        req_if.owner_id     = '0;
        req_if.request_size = '0;
        cfg_if.valid        = 1'b0;
        cfg_if.addr         = '0;
        cfg_if.data         = '0;
        req_idle_en         = 1'b1;
        rsp_idle_en         = 1'b1;
        rsp_hold_cycles     = 0;
        cycle_count         = 0;
        settings_used       = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed requests on the default 1 MiB pool.
        set_pool(32'h0, 5'(POOL_RESET));
        send_request(32'd0, 32'd0);                   // both fields invalid
        send_request(32'd0, 32'd5);                   // zero owner
        send_request(32'd1, 32'd0);                   // zero size
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);   // larger than the pool
        send_request(32'd7, 32'd1);                   // below the smallest block
        send_request(32'd8, 32'd1024);
        send_request(32'd9, 32'd1025);
        send_request(32'd10, 32'd1 << 20);            // whole pool, root already split
        send_request(32'd11, (32'd1 << 20) + 32'd1);
        send_request(32'd12, 32'd1 << 18);
        send_request(32'd13, 32'd3000);
        send_request(32'd14, 32'd512);
        send_request(32'd15, 32'd2);
        send_request(32'd16, 32'd4096);
        send_request(32'h8000_0000, 32'd1024);

        // Tiny pool so that one-byte nodes exist, with a base near the top.
        wait_for_results();
        set_pool(32'hFFFF_FFF0, 5'd3);
        send_request(32'd21, 32'd1);
        send_request(32'd22, 32'd1);
        send_request(32'd23, 32'd2);
        send_request(32'd24, 32'd8);

        // Random phases over several settings; one runs with no idling and the
        // last one starts with a long output stall.
        run_phase(32'($urandom()), 5'd20, 100, 1'b1, 0);
        run_phase(32'hFFFF_FFFF, 5'd12, 40, 1'b0, 0);
        run_phase(32'($urandom()), 5'd31, 40, 1'b1, 0);
        run_phase(32'h0, 5'd0, 20, 1'b1, 0);
        run_phase(32'($urandom()), 5'd16, 70, 1'b1, HOLD_OFF_CYCLES);

        wait_for_results();
        repeat (20) @(negedge clk);
        $display("Covered %0d register settings in %0d cycles", settings_used, cycle_count);
        $display("Grants: %0d ok, %0d no space, %0d invalid owner, %0d invalid size",
                 ledger.status_seen[ST_OK], ledger.status_seen[ST_NO_SPACE],
                 ledger.status_seen[ST_BAD_OWNER], ledger.status_seen[ST_BAD_SIZE]);
        if (ledger.mismatches == 0 && ledger.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/bba_pkg.sv
sv/bba_ifs.sv
sv/bba_node_ram.sv
sv/bba_search.sv
sv/buddy_block_allocator.sv
sv/bba_checker.sv
dv/testbench.sv
